// File: hdl/fth_pkg.sv
// Shared types, codes and constants of the FASTA tetranucleotide histogram unit.
package fth_pkg;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam int KMER_LEN        = 4;
  localparam int HIST_BINS       = 4 ** KMER_LEN;
  localparam int BIN_AW          = 2 * KMER_LEN;
  localparam int WIN_W           = 2 * (KMER_LEN - 1);
  localparam int OUT_W           = 32;
  localparam int GENE_W          = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = 2;
  localparam int FIFO_CW         = FIFO_AW + 1;

  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [1:0] BASES_FULL = 2'(KMER_LEN - 1);

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              inc;
    logic              rd;
    logic              clr;
    logic [BIN_AW-1:0] addr;
    logic [GENE_W-1:0] genes;
  } req_t;

  typedef struct packed {
    logic [GENE_W-1:0] genes;
    logic [OUT_W-1:0]  bin_total;
  } res_t;

endpackage

// File: hdl/fth_parser.sv
// Input register and FASTA line parser that turns bytes and commands into histogram requests.
module fth_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          in_idx,
  output fth_pkg::req_t       req
);

  logic                       in_vld_r;
  fth_pkg::cmd_t              cmd_r;
  logic [7:0]                 byte_r;
  logic [7:0]                 idx_r;

  logic [fth_pkg::WIN_W-1:0]  win_r, win_nxt;
  logic [1:0]                 bases_r, bases_nxt;
  logic                       ls_r, ls_nxt;
  logic                       skip_r, skip_nxt;
  logic [fth_pkg::GENE_W-1:0] genes_r, genes_nxt;

  logic                       skip_now;
  logic                       is_base;
  logic [1:0]                 code;
  logic [fth_pkg::GENE_W-1:0] genes_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= fth_pkg::cmd_t'(in_cmd);
      byte_r <= in_byte;
      idx_r  <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      bases_r <= '0;
      ls_r    <= 1'b1;
      skip_r  <= 1'b1;
      genes_r <= '0;
    end else begin
      win_r   <= win_nxt;
      bases_r <= bases_nxt;
      ls_r    <= ls_nxt;
      skip_r  <= skip_nxt;
      genes_r <= genes_nxt;
    end
  end

  always_comb begin
    is_base = 1'b1;
    code    = fth_pkg::BASE_A;
    unique case (byte_r)
      fth_pkg::CH_A: code = fth_pkg::BASE_A;
      fth_pkg::CH_C: code = fth_pkg::BASE_C;
      fth_pkg::CH_G: code = fth_pkg::BASE_G;
      fth_pkg::CH_T: code = fth_pkg::BASE_T;
      default:       is_base = 1'b0;
    endcase
  end

  assign genes_inc = (&genes_r) ? genes_r : genes_r + {{(fth_pkg::GENE_W-1){1'b0}}, 1'b1};

  always_comb begin
    win_nxt   = win_r;
    bases_nxt = bases_r;
    ls_nxt    = ls_r;
    skip_nxt  = skip_r;
    genes_nxt = genes_r;
    skip_now  = skip_r;
    req       = '0;
    req.genes = genes_r;
    if (in_vld_r) begin
      unique case (cmd_r)
        fth_pkg::CMD_BYTE: begin
          if (ls_r) begin
            ls_nxt = 1'b0;
            if (!skip_r) begin
              if (byte_r == fth_pkg::CH_GT) begin
                genes_nxt = genes_inc;
                win_nxt   = '0;
                bases_nxt = '0;
                skip_now  = 1'b1;
              end else if (byte_r == fth_pkg::CH_LF || byte_r == fth_pkg::CH_CR) begin
                skip_now = 1'b1;
              end
            end
          end
          skip_nxt = skip_now;
          if (byte_r == fth_pkg::CH_LF) begin
            ls_nxt   = 1'b1;
            skip_nxt = 1'b0;
          end else if (!skip_now && is_base) begin
            if (bases_r == fth_pkg::BASES_FULL) begin
              req.inc  = 1'b1;
              req.addr = {win_r, code};
            end else begin
              bases_nxt = bases_r + 2'd1;
            end
            win_nxt = {win_r[fth_pkg::WIN_W-3:0], code};
          end
        end
        fth_pkg::CMD_END: begin
          genes_nxt = genes_inc;
          win_nxt   = '0;
          bases_nxt = '0;
          ls_nxt    = 1'b1;
          skip_nxt  = 1'b1;
        end
        fth_pkg::CMD_READ: begin
          req.rd   = 1'b1;
          req.addr = idx_r;
        end
        fth_pkg::CMD_CLEAR: begin
          win_nxt   = '0;
          bases_nxt = '0;
          ls_nxt    = 1'b1;
          skip_nxt  = 1'b1;
          genes_nxt = '0;
          req.clr   = 1'b1;
        end
        default: begin
          req = '0;
        end
      endcase
    end
  end

endmodule

// File: hdl/fth_hist.sv
// Histogram store with read-modify-write forwarding, valid bits and read result path.
module fth_hist #(
  parameter int COUNT_WIDTH = fth_pkg::DEF_COUNT_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fth_pkg::req_t req,
  output logic          res_push,
  output fth_pkg::res_t res_data,
  output logic          s2_rd
);

  localparam int OW = fth_pkg::OUT_W;

  logic [COUNT_WIDTH-1:0]         mem [fth_pkg::HIST_BINS];
  logic [fth_pkg::HIST_BINS-1:0]  bin_vld_r;

  logic                           s2_inc_r;
  logic                           s2_rd_r;
  logic                           s2_clr_r;
  logic [fth_pkg::BIN_AW-1:0]     s2_addr_r;
  logic [fth_pkg::GENE_W-1:0]     s2_genes_r;
  logic [COUNT_WIDTH-1:0]         rd_data_r;
  logic                           rd_vld_r;

  logic                           fwd_inc_r;
  logic                           fwd_clr_r;
  logic [fth_pkg::BIN_AW-1:0]     fwd_addr_r;
  logic [COUNT_WIDTH-1:0]         fwd_data_r;

  logic [COUNT_WIDTH-1:0]         cur_val;
  logic [COUNT_WIDTH-1:0]         new_val;
  logic [OW-1:0]                  total_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_inc_r  <= 1'b0;
      s2_rd_r   <= 1'b0;
      s2_clr_r  <= 1'b0;
      fwd_inc_r <= 1'b0;
      fwd_clr_r <= 1'b0;
    end else begin
      s2_inc_r  <= req.inc;
      s2_rd_r   <= req.rd;
      s2_clr_r  <= req.clr;
      fwd_inc_r <= s2_inc_r;
      fwd_clr_r <= s2_clr_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r  <= req.addr;
    s2_genes_r <= req.genes;
    fwd_addr_r <= s2_addr_r;
    fwd_data_r <= new_val;
  end

  always_ff @(posedge clk) begin
    if (req.inc || req.rd) begin
      rd_data_r <= mem[req.addr];
      rd_vld_r  <= bin_vld_r[req.addr];
    end
    if (s2_inc_r) begin
      mem[s2_addr_r] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
    end else if (s2_clr_r) begin
      bin_vld_r <= '0;
    end else if (s2_inc_r) begin
      bin_vld_r[s2_addr_r] <= 1'b1;
    end
  end

  // The read issued at the edge of the previous write or clear misses it.
  always_comb begin
    if (fwd_clr_r) begin
      cur_val = '0;
    end else if (fwd_inc_r && fwd_addr_r == s2_addr_r) begin
      cur_val = fwd_data_r;
    end else if (rd_vld_r) begin
      cur_val = rd_data_r;
    end else begin
      cur_val = '0;
    end
  end

  assign new_val = (&cur_val) ? cur_val : cur_val + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  if (COUNT_WIDTH > OW) begin : g_clip
    assign total_clip = (|cur_val[COUNT_WIDTH-1:OW]) ? {OW{1'b1}} : cur_val[OW-1:0];
  end else begin : g_ext
    assign total_clip = OW'(cur_val);
  end

  assign res_push           = s2_rd_r;
  assign res_data.bin_total = total_clip;
  assign res_data.genes     = s2_genes_r;
  assign s2_rd              = s2_rd_r;

endmodule

// File: hdl/fth_out_fifo.sv
// Small result queue that decouples the histogram pipeline from the output channel.
module fth_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  fth_pkg::res_t               push_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fth_pkg::res_t               out_data,
  output logic [fth_pkg::FIFO_CW-1:0] count
);

  fth_pkg::res_t                entries [fth_pkg::FIFO_DEPTH];
  logic [fth_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [fth_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [fth_pkg::FIFO_CW-1:0]  cnt_r;
  logic                         pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/fasta_tetranucleotide_histogram_unit.sv
// Top level of the FASTA tetranucleotide histogram unit.
// Throughput: one input transaction per cycle while in_tready is high; every command passes the same two-stage pipe.
// A read result passes the input register, the histogram stage register and the result queue before out_tvalid.
// in_tready falls only when four read results are queued or in flight (four-entry queue).
// Reset (synchronous, rst_n low) clears the parser, the gene count and all bin valid bits
// together, so the histogram reads as empty with no clearing pass.
module fasta_tetranucleotide_histogram_unit #(
  parameter int COUNT_WIDTH = fth_pkg::DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // text_byte [7:0], bin_index [15:8]
  input  logic [1:0]  in_tuser,   // cmd [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // bin_total [31:0], genes_seen [63:32]
);

  localparam int CRW = fth_pkg::FIFO_CW + 1;

  logic                        in_accept;
  fth_pkg::req_t               req;
  logic                        res_push;
  fth_pkg::res_t               res_data;
  logic                        s2_rd;
  fth_pkg::res_t               out_res;
  logic [fth_pkg::FIFO_CW-1:0] fifo_cnt;
  logic [CRW-1:0]              credit_used;

  assign credit_used = CRW'(fifo_cnt) + CRW'(req.rd) + CRW'(s2_rd);
  assign in_tready   = (credit_used < CRW'(fth_pkg::FIFO_DEPTH));
  assign in_accept   = in_tvalid && in_tready;

  fth_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_cmd    (in_tuser),
    .in_byte   (in_tdata[7:0]),
    .in_idx    (in_tdata[15:8]),
    .req       (req)
  );

  fth_hist #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .res_push (res_push),
    .res_data (res_data),
    .s2_rd    (s2_rd)
  );

  fth_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res),
    .count     (fifo_cnt)
  );

  assign out_tdata = {out_res.genes, out_res.bin_total};

endmodule

// File: hdl/fth_checker.sv
// Port-level assertions for the FASTA tetranucleotide histogram unit and their binding.
module fth_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or was dropped.");

  a_rise_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && (in_tuser == fth_pkg::CMD_READ), 3))
    else $error("Result appeared without a read transaction three cycles earlier.");

  a_stall_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("Input stalled while no result was waiting.");

endmodule

bind fasta_tetranucleotide_histogram_unit fth_checker u_fth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/fasta_tetranucleotide_histogram_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the FASTA tetranucleotide histogram unit: tracks the parser and histogram, checks reads.
module fasta_tetranucleotide_histogram_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // text_byte [7:0], bin_index [15:8]
  input  logic [1:0]  in_tuser,   // cmd [1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // bin_total [31:0], genes_seen [63:32]
  output int          mismatches,
  output int          reads_pending
);

  logic [fth_pkg::OUT_W-1:0]  bin_count [fth_pkg::HIST_BINS];
  logic [fth_pkg::WIN_W-1:0]  window;
  logic [1:0]                 base_fill;
  logic                       line_head;
  logic                       skip_line;
  logic [fth_pkg::GENE_W-1:0] gene_total;
  fth_pkg::res_t              awaited_reads [$];
  fth_pkg::res_t              want;
  int                         error_total = 0;

  assign mismatches = error_total;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, wanted);
    error_total++;
  endtask

  function automatic void clear_model();
    for (int i = 0; i < fth_pkg::HIST_BINS; i++) bin_count[i] = '0;
    window     = '0;
    base_fill  = '0;
    line_head  = 1'b1;
    skip_line  = 1'b1;
    gene_total = '0;
  endfunction

  function automatic void end_gene();
    if (gene_total != '1) gene_total++;
    window    = '0;
    base_fill = '0;
  endfunction

  function automatic void shift_base(logic [1:0] code);
    logic [fth_pkg::BIN_AW-1:0] bin;
    bin = {window, code};
    if (base_fill >= fth_pkg::BASES_FULL) begin
      if (bin_count[bin] != '1) bin_count[bin]++;
    end else begin
      base_fill++;
    end
    window = {window[fth_pkg::WIN_W-3:0], code};
  endfunction

  function automatic void scan_char(logic [7:0] b);
    if (line_head) begin
      line_head = 1'b0;
      if (!skip_line) begin
        if (b == fth_pkg::CH_GT) begin
          end_gene();
          skip_line = 1'b1;
        end else if (b == fth_pkg::CH_LF || b == fth_pkg::CH_CR) begin
          skip_line = 1'b1;
        end
      end
    end
    if (b == fth_pkg::CH_LF) begin
      line_head = 1'b1;
      skip_line = 1'b0;
    end else if (!skip_line) begin
      case (b)
        fth_pkg::CH_A: shift_base(fth_pkg::BASE_A);
        fth_pkg::CH_C: shift_base(fth_pkg::BASE_C);
        fth_pkg::CH_G: shift_base(fth_pkg::BASE_G);
        fth_pkg::CH_T: shift_base(fth_pkg::BASE_T);
        default: ;
      endcase
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      awaited_reads.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_reads.size() == 0) begin
          report_mismatch("result with no read pending", out_tdata[31:0], '0);
        end else begin
          want = awaited_reads.pop_front();
          if (out_tdata[31:0] !== want.bin_total)
            report_mismatch("bin_total", out_tdata[31:0], want.bin_total);
          if (out_tdata[63:32] !== want.genes)
            report_mismatch("genes_seen", out_tdata[63:32], want.genes);
        end
      end
      if (in_tvalid && in_tready) begin
        case (fth_pkg::cmd_t'(in_tuser))
          fth_pkg::CMD_BYTE: scan_char(in_tdata[7:0]);
          fth_pkg::CMD_END: begin
            end_gene();
            line_head = 1'b1;
            skip_line = 1'b1;
          end
          fth_pkg::CMD_READ: begin
            want.bin_total = bin_count[in_tdata[15:8]];
            want.genes     = gene_total;
            awaited_reads.push_back(want);
          end
          fth_pkg::CMD_CLEAR: clear_model();
          default: ;
        endcase
      end
    end
    reads_pending <= awaited_reads.size();
  end

endmodule

// File: tb/fasta_tetranucleotide_histogram_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the FASTA tetranucleotide histogram unit: stimulus, back-pressure and verdict.
module fasta_tetranucleotide_histogram_unit_tb;

  localparam int TOTAL_ITEMS = 945;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  int          mismatches;
  int          reads_pending;
  int          items_sent = 0;
  int          idle_cycles = 0;

  always #10 clk = ~clk;

  fasta_tetranucleotide_histogram_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fasta_tetranucleotide_histogram_unit_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .reads_pending (reads_pending)
  );

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(fth_pkg::cmd_t c, logic [7:0] b, logic [7:0] idx);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {idx, b};
    in_tuser  <= c;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] b);
    send_item(fth_pkg::CMD_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic read_bin(logic [7:0] idx);
    send_item(fth_pkg::CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic drain_results();
    int gap;
    int taken;
    taken = 0;
    forever begin
      // One long hold-off fills the result queue and stalls the input side.
      gap = (taken == 8) ? HOLD_CYCLES : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("fasta_tetranucleotide_histogram_unit_tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    int        r;
    int        len;
    bit        narrow;
    logic [1:0] code;
    logic [7:0] ch;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= fth_pkg::CMD_BYTE;
    out_tready <= 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    read_bin(8'h00);
    send_text("AC\n");
    send_text("AAAAaT\n");
    send_text("\015G\n");
    send_text(">\n");
    send_text("TTTT");
    send_item(fth_pkg::CMD_END, 8'hFF, 8'h00);
    read_bin(8'hFF);
    read_bin(8'h03);
    send_item(fth_pkg::CMD_CLEAR, 8'h00, 8'hFF);
    read_bin(8'h00);

    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        narrow = 1'($urandom_range(0, 1));
        len    = $urandom_range(1, 14);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            ch = 8'($urandom_range(0, 255));
          end else begin
            code = narrow ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
            case (code)
              fth_pkg::BASE_A: ch = fth_pkg::CH_A;
              fth_pkg::BASE_C: ch = fth_pkg::CH_C;
              fth_pkg::BASE_G: ch = fth_pkg::CH_G;
              default: ch = fth_pkg::CH_T;
            endcase
          end
          send_char(ch);
        end
        if ($urandom_range(0, 3) == 0) send_char(fth_pkg::CH_CR);
        send_char(fth_pkg::CH_LF);
      end else if (r < 55) begin
        send_char(fth_pkg::CH_GT);
        repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(32, 126)));
        send_char(fth_pkg::CH_LF);
      end else if (r < 60) begin
        if ($urandom_range(0, 1) == 1) send_char(fth_pkg::CH_CR);
        send_char(fth_pkg::CH_LF);
      end else if (r < 82) begin
        if ($urandom_range(0, 1) == 1) read_bin(8'($urandom_range(0, 255)));
        else read_bin(8'($urandom_range(0, 255)) & 8'h55);
      end else if (r < 92) begin
        send_char(8'($urandom_range(0, 255)));
      end else if (r < 98) begin
        send_item(fth_pkg::CMD_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_item(fth_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
    in_tvalid <= 1'b0;

    while (reads_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("fasta_tetranucleotide_histogram_unit_tb OK");
    end else begin
      $display("fasta_tetranucleotide_histogram_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/fth_pkg.sv
hdl/fth_parser.sv
hdl/fth_hist.sv
hdl/fth_out_fifo.sv
hdl/fasta_tetranucleotide_histogram_unit.sv
hdl/fth_checker.sv
tb/fasta_tetranucleotide_histogram_unit_checker.sv
tb/fasta_tetranucleotide_histogram_unit_tb.sv
